@@ rtl/core/kesd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the keyword entry stream decoder.
// No dependencies; imported by every module of the block.
package kesd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int LEN_W       = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_EXT_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN = 2'd1;

  localparam logic [LEN_W-1:0] HDR_BYTES = 31'd8;

  typedef enum logic [2:0] {
    KIND_OK    = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_TAG   = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_SKIP  = 3'd4,
    KIND_BAD   = 3'd5
  } kind_t;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_VALUE  = 6'b000010,
    PH_TAG    = 6'b000100,
    PH_PAD    = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_IDLE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [7:0]       type_code;
    logic [LEN_W-1:0] elem_count;
    logic [LEN_W-1:0] entry_length;
    logic             last;
  } result_t;

  // Up to one command per byte: element bytes, then a tag byte, then a closing result.
  typedef struct packed {
    logic [3:0]       elem_n;
    logic [63:0]      elem_buf;
    logic             tag_v;
    logic [7:0]       tag_byte;
    logic             end_v;
    kind_t            end_kind;
    logic [7:0]       type_code;
    logic [LEN_W-1:0] elem_count;
    logic [LEN_W-1:0] entry_length;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [3:0] type_width(input logic [7:0] t);
    logic [3:0] s;
    unique case (t)
      8'h42, 8'h41:        s = 4'd1; // B, A
      8'h49:               s = 4'd2; // I
      8'h4C, 8'h46, 8'h54: s = 4'd4; // L, F, T
      8'h58, 8'h44:        s = 4'd8; // X, D
      default:             s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] elem_shift(input logic [3:0] s);
    logic [1:0] r;
    unique case (s)
      4'd2:    r = 2'd1;
      4'd4:    r = 2'd2;
      4'd8:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/kesd_front.sv @@
`timescale 1ns / 1ps
// Front end: walks the byte stream, decodes headers and emits up to one command per byte.
// Depends on kesd_pkg.
module kesd_front import kesd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] ext_length,
  input  logic             big_endian,
  input  logic             take,
  input  in_item_t         item,
  output logic             push,
  output cmd_t             cmd
);

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] walk_offset, walk_offset_next;
  logic [LEN_W-1:0] entry_offset, entry_offset_next;
  logic [3:0]       fill, fill_next;
  logic [55:0]      hdr_shift, hdr_shift_next;
  logic [LEN_W-1:0] entry_bytes, entry_bytes_next;
  logic [LEN_W-1:0] value_end, value_end_next;
  logic [LEN_W-1:0] tag_end, tag_end_next;
  logic [7:0]       tag_bytes, tag_bytes_next;
  logic [7:0]       type_code, type_code_next;
  logic [3:0]       esz, esz_next;
  logic [LEN_W-1:0] elem_count, elem_count_next;
  logic [63:0]      elem_buf, elem_buf_next;

  phase_t           eff_phase;
  logic [LEN_W-1:0] eff_off, eff_eo, off_inc, avail, vb, eb_sel, eo_sum;
  logic [3:0]       eff_fill, fill_inc, new_esz;
  logic [63:0]      hfull, merged;
  logic [31:0]      k;
  logic [15:0]      x;
  logic [8:0]       hsum;
  logic             bad, odd;

  always_comb begin
    eff_phase = item.first_byte ? PH_HEADER : phase;
    eff_off   = item.first_byte ? '0 : walk_offset;
    eff_eo    = item.first_byte ? '0 : entry_offset;
    eff_fill  = item.first_byte ? '0 : fill;
    off_inc   = eff_off + 31'd1;
    fill_inc  = eff_fill + 4'd1;
    hfull     = {hdr_shift, item.byte_value};
    merged    = elem_buf;
    merged[eff_fill[2:0]*8 +: 8] = item.byte_value;

    if (big_endian) begin
      k = hfull[63:32];
      x = hfull[31:16];
    end else begin
      k = {hfull[39:32], hfull[47:40], hfull[55:48], hfull[63:56]};
      x = {hfull[23:16], hfull[31:24]};
    end
    avail = (ext_length > eff_eo) ? ext_length - eff_eo : '0;
    hsum  = 9'd8 + {1'b0, hfull[15:8]};
    // 8 + value + tag > entry reduces to 8 + tag > non-value length once x <= k
    bad = (avail < HDR_BYTES) || k[31] || (k[30:0] < HDR_BYTES) || x[15] ||
          (x < 16'd8) || (k > {1'b0, avail}) || ({16'd0, x} > k) ||
          ({7'd0, hsum} > x);
    vb      = k[30:0] - {15'd0, x};
    new_esz = type_width(hfull[7:0]);
    odd     = (new_esz == 4'd0) || (vb == '0) ||
              ((vb[2:0] & (new_esz[2:0] - 3'd1)) != 3'd0);
    eb_sel  = (eff_phase == PH_HEADER) ? k[30:0] : entry_bytes;
    eo_sum  = eff_eo + eb_sel;
  end

  always_comb begin
    phase_next        = phase;
    walk_offset_next  = walk_offset;
    entry_offset_next = entry_offset;
    fill_next         = fill;
    hdr_shift_next    = hdr_shift;
    entry_bytes_next  = entry_bytes;
    value_end_next    = value_end;
    tag_end_next      = tag_end;
    tag_bytes_next    = tag_bytes;
    type_code_next    = type_code;
    esz_next          = esz;
    elem_count_next   = elem_count;
    elem_buf_next     = elem_buf;
    cmd               = '0;
    cmd.end_kind      = KIND_DONE;
    cmd.type_code     = type_code;
    cmd.elem_count    = elem_count;
    cmd.entry_length  = entry_bytes;

    if (take) begin
      phase_next        = eff_phase;
      walk_offset_next  = off_inc;
      entry_offset_next = eff_eo;
      fill_next         = eff_fill;
      unique case (eff_phase)
        PH_HEADER: begin
          hdr_shift_next = hfull[55:0];
          if (off_inc == HDR_BYTES) begin
            type_code_next = hfull[7:0];
            tag_bytes_next = hfull[15:8];
            cmd.type_code  = hfull[7:0];
            cmd.end_v      = 1'b1;
            if (bad) begin
              cmd.end_kind     = KIND_BAD;
              cmd.elem_count   = '0;
              cmd.entry_length = '0;
              phase_next       = PH_IDLE;
            end else begin
              entry_bytes_next = k[30:0];
              value_end_next   = vb + HDR_BYTES;
              tag_end_next     = vb + HDR_BYTES + {23'd0, hfull[15:8]};
              esz_next         = new_esz;
              elem_count_next  = vb >> elem_shift(new_esz);
              fill_next        = '0;
              cmd.entry_length = k[30:0];
              if (odd) begin
                cmd.end_kind   = KIND_SKIP;
                cmd.elem_count = '0;
                if (k[30:0] == HDR_BYTES) begin
                  entry_offset_next = eo_sum;
                  walk_offset_next  = '0;
                  phase_next = (eo_sum >= ext_length) ? PH_IDLE : PH_HEADER;
                end else begin
                  phase_next = PH_SKIP;
                end
              end else begin
                cmd.end_kind   = KIND_OK;
                cmd.elem_count = vb >> elem_shift(new_esz);
                phase_next     = PH_VALUE;
              end
            end
          end
        end
        PH_SKIP: begin
          if (off_inc >= entry_bytes) begin
            entry_offset_next = eo_sum;
            walk_offset_next  = '0;
            fill_next         = '0;
            phase_next = (eo_sum >= ext_length) ? PH_IDLE : PH_HEADER;
          end
        end
        PH_VALUE, PH_TAG, PH_PAD: begin
          if (eff_phase == PH_VALUE) begin
            elem_buf_next = merged;
            if (fill_inc >= esz) begin
              cmd.elem_n   = esz;
              cmd.elem_buf = merged;
              fill_next    = '0;
            end else begin
              fill_next = fill_inc;
            end
            if (off_inc >= value_end) begin
              phase_next = (tag_bytes != 8'd0) ? PH_TAG : PH_PAD;
            end
          end else if (eff_phase == PH_TAG) begin
            cmd.tag_v    = 1'b1;
            cmd.tag_byte = item.byte_value;
            if (off_inc >= tag_end) begin
              phase_next = PH_PAD;
            end
          end
          if (off_inc >= entry_bytes) begin
            cmd.end_v         = 1'b1;
            cmd.end_kind      = KIND_DONE;
            entry_offset_next = eo_sum;
            walk_offset_next  = '0;
            fill_next         = '0;
            phase_next = (eo_sum >= ext_length) ? PH_IDLE : PH_HEADER;
          end
        end
        default: begin
          walk_offset_next = eff_off;
        end
      endcase
    end
  end

  assign push = take && ((cmd.elem_n != 4'd0) || cmd.tag_v || cmd.end_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      walk_offset  <= '0;
      entry_offset <= '0;
      fill         <= '0;
    end else begin
      phase        <= phase_next;
      walk_offset  <= walk_offset_next;
      entry_offset <= entry_offset_next;
      fill         <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr_shift   <= hdr_shift_next;
    entry_bytes <= entry_bytes_next;
    value_end   <= value_end_next;
    tag_end     <= tag_end_next;
    tag_bytes   <= tag_bytes_next;
    type_code   <= type_code_next;
    esz         <= esz_next;
    elem_count  <= elem_count_next;
    elem_buf    <= elem_buf_next;
  end

endmodule

@@ rtl/core/kesd_queue.sv @@
`timescale 1ns / 1ps
// Command queue between the front and back ends; head is read in place.
// Depends on kesd_pkg.
module kesd_queue import kesd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/kesd_back.sv @@
`timescale 1ns / 1ps
// Back end: expands queue heads into results, one per cycle unless stalled.
// Depends on kesd_pkg.
module kesd_back import kesd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    big_endian,
  input  cmd_t    head,
  input  q_stat_t stat,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result_item
);

  logic [3:0] idx;
  logic       tag_sent;
  logic       advance, is_value, is_tag, lastf;
  logic [3:0] rev;
  logic [2:0] src;
  result_t    nxt;

  assign advance = !stat.empty && (!result_valid || result_ready);
  assign pop     = advance && lastf;

  always_comb begin
    rev      = head.elem_n - 4'd1 - idx;
    src      = big_endian ? rev[2:0] : idx[2:0];
    is_value = (idx < head.elem_n);
    is_tag   = !is_value && head.tag_v && !tag_sent;
    nxt              = '0;
    nxt.type_code    = head.type_code;
    nxt.elem_count   = head.elem_count;
    nxt.entry_length = head.entry_length;
    if (is_value) begin
      nxt.kind      = KIND_VALUE;
      nxt.data_byte = head.elem_buf[src*8 +: 8];
      lastf = !head.tag_v && !head.end_v && ((idx + 4'd1) == head.elem_n);
    end else if (is_tag) begin
      nxt.kind      = KIND_TAG;
      nxt.data_byte = head.tag_byte;
      lastf = !head.end_v;
    end else begin
      nxt.kind = head.end_kind;
      lastf    = 1'b1;
    end
    nxt.last = lastf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
      tag_sent     <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
      if (lastf) begin
        idx      <= '0;
        tag_sent <= 1'b0;
      end else if (is_value) begin
        idx <= idx + 4'd1;
      end else begin
        tag_sent <= 1'b1;
      end
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item <= nxt;
    end
  end

endmodule

@@ rtl/core/keyword_entry_stream_decoder.sv @@
`timescale 1ns / 1ps
// Keyword entry stream decoder top: config registers, front end, command queue, back end.
// Result path: an accepted byte's command is written into the queue, and the back end
// registers each result from the queue head into the output register.
// Throughput: one byte per cycle; the back end gives one result per cycle while the
// output is ready; a byte with up to 9 results stalls input only once the queue fills.
// Reset (synchronous, rst high): walk at header phase, queue empty, registers cleared.
// Depends on kesd_pkg, kesd_front, kesd_queue, kesd_back.
module keyword_entry_stream_decoder import kesd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  in_item_t               byte_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [LEN_W-1:0] ext_length;
  logic             big_endian;
  logic             take, push, pop;
  cmd_t             push_cmd, head;
  q_stat_t          stat;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !stat.full;
  assign take       = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_length <= '0;
      big_endian <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_EXT_LENGTH) begin
        ext_length <= cfg_data;
      end else if (cfg_index == REG_BIG_ENDIAN) begin
        big_endian <= cfg_data[0];
      end
    end
  end

  kesd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ext_length (ext_length),
    .big_endian (big_endian),
    .take       (take),
    .item       (byte_item),
    .push       (push),
    .cmd        (push_cmd)
  );

  kesd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  kesd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .big_endian   (big_endian),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("command popped from empty queue");

  a_push_on_take: assert property (@(posedge clk) disable iff (rst) push |-> take)
    else $error("command pushed without an accepted byte");

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.kind == KIND_OK || result_item.kind == KIND_VALUE ||
                      result_item.kind == KIND_TAG || result_item.kind == KIND_DONE ||
                      result_item.kind == KIND_SKIP || result_item.kind == KIND_BAD))
    else $error("result kind out of range");

endmodule

@@ tb/keyword_entry_stream_decoder_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyword_entry_stream_decoder: random-stall byte driver,
// result monitor with a byte-level predictor of the entry walk. Depends on kesd_pkg.
module keyword_entry_stream_decoder_test;
  import kesd_pkg::*;

  localparam int WALK_HEADER = 0;
  localparam int WALK_VALUE  = 1;
  localparam int WALK_TAG    = 2;
  localparam int WALK_PAD    = 3;
  localparam int WALK_SKIP   = 4;
  localparam int WALK_ERROR  = 5;
  localparam int WALK_IDLE   = 6;
  localparam int STALL_LIMIT = 3000;
  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  in_item_t byte_item = '0;
  logic result_valid;
  logic result_ready = 1'b1;
  result_t result_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keyword_entry_stream_decoder uut (.*);

  initial forever #6 clk = ~clk;

  in_item_t pending_bytes[$];
  result_t expected_results[$];
  int errors = 0;
  int queued = 0;
  bit calm = 1'b0;

  // predictor state
  logic [31:0] p_ext_len;
  logic        p_big;
  int          p_phase;
  logic [31:0] p_walk, p_start, p_entry, p_value;
  logic [63:0] p_shift;
  logic [7:0]  p_tag, p_type;
  logic [3:0]  p_esz, p_fill;
  logic [7:0]  p_ebuf[8];

  function automatic logic [3:0] type_size(input logic [7:0] t);
    case (t)
      "B", "A":      return 4'd1;
      "I":           return 4'd2;
      "L", "F", "T": return 4'd4;
      "X", "D":      return 4'd8;
      default:       return 4'd0;
    endcase
  endfunction

  function automatic logic [30:0] elem_total();
    return (p_esz != 0) ? 31'(p_value / p_esz) : 31'd0;
  endfunction

  function automatic result_t mk(kind_t k, logic [7:0] d, logic [30:0] c, logic [30:0] l);
    result_t r;
    r.kind = k; r.data_byte = d; r.type_code = p_type;
    r.elem_count = c; r.entry_length = l; r.last = 1'b0;
    return r;
  endfunction

  task automatic close_entry();
    p_start = p_start + p_entry;
    p_walk = 0; p_shift = 0; p_fill = 0;
    p_phase = (p_start >= p_ext_len) ? WALK_IDLE : WALK_HEADER;
  endtask

  task automatic decode_header(ref result_t res[$]);
    logic [7:0] h[8];
    logic [31:0] k, x, avail;
    longint need;
    for (int i = 0; i < 8; i++) h[i] = p_shift[56-8*i +: 8];
    if (p_big) begin
      k = {h[0], h[1], h[2], h[3]}; x = {16'd0, h[4], h[5]};
    end else begin
      k = {h[3], h[2], h[1], h[0]}; x = {16'd0, h[5], h[4]};
    end
    p_tag = h[6];
    p_type = h[7];
    avail = (p_ext_len > p_start) ? p_ext_len - p_start : 0;
    need = 8 + longint'(k) - longint'(x) + p_tag;
    if (avail < 8 || k[31] || k < 8 || x[15] || x < 8 || k > avail || x > k ||
        need > longint'(k)) begin
      res.push_back(mk(KIND_BAD, 8'd0, 31'd0, 31'd0));
      p_phase = WALK_ERROR;
      return;
    end
    p_entry = k;
    p_value = k - x;
    p_esz = type_size(p_type);
    p_fill = 0;
    if (p_esz == 0 || p_value == 0 || (p_value % p_esz) != 0) begin
      res.push_back(mk(KIND_SKIP, 8'd0, 31'd0, k[30:0]));
      if (p_walk >= p_entry) close_entry();
      else p_phase = WALK_SKIP;
      return;
    end
    res.push_back(mk(KIND_OK, 8'd0, elem_total(), k[30:0]));
    p_phase = WALK_VALUE;
  endtask

  task automatic predict_byte(input in_item_t it);
    result_t res[$];
    logic [7:0] b;
    logic [3:0] src;
    b = it.byte_value;
    if (it.first_byte) begin
      p_phase = WALK_HEADER; p_walk = 0; p_start = 0; p_shift = 0; p_fill = 0;
    end
    case (p_phase)
      WALK_HEADER: begin
        p_shift = {p_shift[55:0], b};
        p_walk++;
        if (p_walk >= 8) decode_header(res);
      end
      WALK_SKIP: begin
        p_walk++;
        if (p_walk >= p_entry) close_entry();
      end
      WALK_VALUE, WALK_TAG, WALK_PAD: begin
        p_walk++;
        if (p_phase == WALK_VALUE) begin
          p_ebuf[p_fill[2:0]] = b;
          p_fill++;
          if (p_fill >= p_esz) begin
            for (int i = 0; i < p_esz; i++) begin
              src = p_big ? 4'(p_esz - 1 - i) : 4'(i);
              res.push_back(mk(KIND_VALUE, p_ebuf[src[2:0]], elem_total(), p_entry[30:0]));
            end
            p_fill = 0;
          end
          if (p_walk >= 8 + p_value) p_phase = (p_tag != 0) ? WALK_TAG : WALK_PAD;
        end else if (p_phase == WALK_TAG) begin
          res.push_back(mk(KIND_TAG, b, elem_total(), p_entry[30:0]));
          if (p_walk >= 8 + p_value + p_tag) p_phase = WALK_PAD;
        end
        if (p_walk >= p_entry) begin
          res.push_back(mk(KIND_DONE, 8'd0, elem_total(), p_entry[30:0]));
          close_entry();
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // byte driver
  int byte_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      byte_gap <= 0;
    end else if (!byte_valid || byte_ready) begin
      if (byte_gap > 0) begin
        byte_gap <= byte_gap - 1;
        byte_valid <= 1'b0;
      end else if (pending_bytes.size() > 0 && !calm && $urandom_range(0, 11) == 0) begin
        byte_gap <= $urandom_range(0, 16);
        byte_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        byte_item <= pending_bytes.pop_front();
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // result monitor, ready stalls and watchdog
  int ready_gap = 0;
  int quiet = 0;
  result_t want;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b1;
      quiet <= 0;
    end else begin
      if (byte_valid && byte_ready) predict_byte(byte_item);
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d data=%0h", result_item.kind, result_item.data_byte);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result_item.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, result_item.kind); errors++;
          end
          if (result_item.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, result_item.data_byte);
            errors++;
          end
          if (result_item.type_code !== want.type_code) begin
            $error("type_code: expected %0h, got %0h", want.type_code, result_item.type_code);
            errors++;
          end
          if (result_item.elem_count !== want.elem_count) begin
            $error("elem_count: expected %0d, got %0d", want.elem_count,
                   result_item.elem_count);
            errors++;
          end
          if (result_item.entry_length !== want.entry_length) begin
            $error("entry_length: expected %0d, got %0d", want.entry_length,
                   result_item.entry_length);
            errors++;
          end
          if (result_item.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result_item.last); errors++;
          end
        end
      end
      if (ready_gap > 0) begin
        ready_gap <= ready_gap - 1;
        result_ready <= (ready_gap == 1);
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        ready_gap <= $urandom_range(1, 17);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
      if ((byte_valid && byte_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("** keyword_entry_stream_decoder: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit fb);
    in_item_t it;
    it.byte_value = b;
    it.first_byte = fb;
    pending_bytes.push_back(it);
    queued++;
  endtask

  // one keyword entry: header, vb value bytes, tag, padding
  task automatic push_entry(input logic [7:0] t, input int vb, input int tg, input int pd,
                            input bit be, input bit fb);
    logic [31:0] k;
    logic [15:0] x;
    k = 8 + vb + tg + pd;
    x = 16'(8 + tg + pd);
    if (be) begin
      push_byte(k[31:24], fb); push_byte(k[23:16], 0); push_byte(k[15:8], 0);
      push_byte(k[7:0], 0); push_byte(x[15:8], 0); push_byte(x[7:0], 0);
    end else begin
      push_byte(k[7:0], fb); push_byte(k[15:8], 0); push_byte(k[23:16], 0);
      push_byte(k[31:24], 0); push_byte(x[7:0], 0); push_byte(x[15:8], 0);
    end
    push_byte(8'(tg), 0);
    push_byte(t, 0);
    repeat (vb + tg + pd) push_byte(8'($urandom), 0);
  endtask

  task automatic random_traffic(input int n_bytes, input bit be);
    int stop, r, es, vb;
    logic [7:0] t;
    logic [7:0] types[8] = '{"B", "I", "L", "X", "F", "D", "A", "T"};
    stop = queued + n_bytes;
    while (queued < stop) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else if (r < 12) begin
        repeat (8) push_byte(8'($urandom), 0);
      end else begin
        // a fresh walk of a few entries
        for (int e = 0; e < $urandom_range(1, 4); e++) begin
          t = ($urandom_range(0, 9) == 0) ? 8'($urandom) : types[$urandom_range(0, 7)];
          es = type_size(t);
          if (es == 0) es = 1;
          vb = es * $urandom_range((es == 8) ? 1 : 0, (es == 8) ? 1 : 3);
          if ($urandom_range(0, 9) == 0) vb = $urandom_range(1, 9);
          push_entry(t, vb, $urandom_range(0, 3), $urandom_range(0, 3), be, e == 0);
        end
      end
    end
  endtask

  task automatic wait_quiet();
    while (pending_bytes.size() != 0 || byte_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_EXT_LENGTH) p_ext_len = {1'b0, val};
    else if (idx == REG_BIG_ENDIAN) p_big = val[0];
  endtask

  task automatic set_mode(input logic [30:0] len, input bit be);
    wait_quiet();
    write_reg(REG_EXT_LENGTH, len);
    write_reg(REG_BIG_ENDIAN, {30'd0, be});
  endtask

  initial begin
    p_ext_len = 0; p_big = 0; p_phase = WALK_HEADER;
    p_walk = 0; p_start = 0; p_shift = 0; p_entry = 0; p_value = 0;
    p_tag = 0; p_type = 0; p_esz = 0; p_fill = 0;
    foreach (p_ebuf[i]) p_ebuf[i] = 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no first byte yet and zero length: header is malformed
    repeat (8) push_byte(8'hFF, 0);

    set_mode(31'd200, 1'b0);
    push_entry("I", 2, 1, 1, 0, 1);
    push_entry("Q", 1, 0, 0, 0, 0);      // unknown type, skipped
    push_byte(8'h04, 0);                 // entry length below header size
    repeat (7) push_byte(8'h00, 0);
    push_byte(8'h00, 0);                 // ignored after a bad header

    set_mode(LEN_MAX, 1'b1);
    push_entry("X", 8, 0, 0, 1, 1);      // widest element, most results per byte
    push_entry("L", 0, 0, 0, 1, 0);      // no value bytes: skipped, ends on header
    push_entry("I", 3, 0, 0, 1, 0);      // value size not a multiple
    push_byte(8'h00, 1);                 // restart in the middle of a header
    push_byte(8'h00, 0);
    push_entry("B", 2, 1, 0, 1, 1);

    set_mode(31'd60, 1'b0);
    random_traffic(45, 0);

    // short remainder, walk completion and a length shrunk below the entry start
    set_mode(31'd24, 1'b1);
    random_traffic(30, 1);
    set_mode(31'd3, 1'b1);
    repeat (10) push_byte(8'($urandom), 0);

    set_mode(LEN_MAX, 1'b0);
    random_traffic(25, 0);
    wait_quiet();               // sender holds off until every result has drained
    random_traffic(15, 0);
    calm = 1'b1;
    random_traffic(15, 0);

    wait_quiet();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("** keyword_entry_stream_decoder: PASSED **");
    else
      $display("** keyword_entry_stream_decoder: FAILED **");
    $finish;
  end

endmodule
